@@ hw/rtl/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants of the callsign route table
// Field widths, operation and status codes, register indexes and the
// callsign normalisation used when storing and comparing keys.
// ----------------------------------------------------------------------------
package crt_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int KEY_W    = 56;
	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 8;
	localparam int ENTRY_W  = KEY_W + IP_W + PORT_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DEFAULT_TABLE_DEPTH = 128;

	typedef logic [OP_W-1:0]       op_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [IP_W-1:0]       ip_t;
	typedef logic [PORT_W-1:0]     port_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [ENTRY_W-1:0]    entry_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// operation codes
	localparam op_t OP_ADD    = 2'd0;
	localparam op_t OP_LOOKUP = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	// result status codes
	localparam status_t STATUS_ADDED   = 3'd0;
	localparam status_t STATUS_FULL    = 3'd1;
	localparam status_t STATUS_CLEARED = 3'd2;
	localparam status_t STATUS_FOUND   = 3'd3;
	localparam status_t STATUS_DEFAULT = 3'd4;
	localparam status_t STATUS_MISS    = 3'd5;

	// register indexes
	localparam cfg_idx_t CFG_DEFAULT_VALID = 2'd0;
	localparam cfg_idx_t CFG_DEFAULT_IP    = 2'd1;
	localparam cfg_idx_t CFG_DEFAULT_PORT  = 2'd2;

	// normalisation masks
	localparam logic [47:0] CHAR_MASK = 48'hfefe_fefe_fefe;
	localparam logic [7:0]  SSID_KEEP = 8'h1e;
	localparam logic [7:0]  SSID_SET  = 8'h60;

	// six character bytes lose their low bit, ssid byte keeps only the ssid and sets bits 6:5
	function automatic key_t normalise(input key_t raw);
		normalise = {raw[55:8] & CHAR_MASK, (raw[7:0] & SSID_KEEP) | SSID_SET};
	endfunction

endpackage

@@ hw/rtl/crt_if.sv @@
// ----------------------------------------------------------------------------
// crt_if: request and response channels of the callsign route table
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface crt_req_if;
	import crt_pkg::*;

	logic  valid;
	logic  ready;
	op_t   operation;
	key_t  callsign;
	ip_t   ip_addr;
	port_t dst_port;

	modport source (output valid, operation, callsign, ip_addr, dst_port, input ready);
	modport sink   (input valid, operation, callsign, ip_addr, dst_port, output ready);
endinterface

interface crt_rsp_if;
	import crt_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	ip_t     route_ip;
	port_t   route_port;
	count_t  entry_count;

	modport source (output valid, status, route_ip, route_port, entry_count, input ready);
	modport sink   (input valid, status, route_ip, route_port, entry_count, output ready);
endinterface

@@ hw/rtl/crt_mem.sv @@
// ----------------------------------------------------------------------------
// crt_mem: route entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module crt_mem #(
	parameter int DEPTH = crt_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX_W = 7
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  crt_pkg::entry_t       wdata,
	input  logic [IDX_W-1:0]      raddr,
	output crt_pkg::entry_t       rdata
);
	import crt_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	assign rdata = rd_data_q;

endmodule

@@ hw/rtl/crt_ctrl.sv @@
// ----------------------------------------------------------------------------
// crt_ctrl: route table sequencer
// Takes one transaction at a time, appends routes, clears the count and
// scans the entry memory one entry a cycle for lookups.
// ----------------------------------------------------------------------------
module crt_ctrl #(
	parameter int TABLE_DEPTH = crt_pkg::DEFAULT_TABLE_DEPTH,
	parameter int IDX_W       = 7,
	parameter int CNT_W       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	crt_req_if.sink              req,
	crt_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  crt_pkg::cfg_idx_t    cfg_index,
	input  crt_pkg::cfg_data_t   cfg_data,
	output logic                 mem_we,
	output logic [IDX_W-1:0]     mem_waddr,
	output crt_pkg::entry_t      mem_wdata,
	output logic [IDX_W-1:0]     mem_raddr,
	input  crt_pkg::entry_t      mem_rdata
);
	import crt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_inc;

	op_t   op_q;
	key_t  key_q;
	ip_t   ip_q;
	port_t port_q;

	status_t res_status_q;
	ip_t     res_ip_q;
	port_t   res_port_q;

	logic  default_valid_q;
	ip_t   default_ip_q;
	port_t default_port_q;

	logic    out_valid_q;
	status_t out_status_q;
	ip_t     out_ip_q;
	port_t   out_port_q;
	count_t  out_count_q;

	logic    hit;
	logic    last;
	logic    out_free;
	status_t dflt_status;
	ip_t     dflt_ip;
	port_t   dflt_port;
	count_t  count_sat;

	// memory access: append at count, scan reads one entry ahead
	always_comb begin
		idx_inc   = idx_q + 1'b1;
		mem_we    = (state_q == S_EXEC) && (op_q == OP_ADD) && (count_q < DEPTH_C);
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = {key_q, ip_q, port_q};
		mem_raddr = (state_q == S_EXEC) ? '0 : idx_inc[IDX_W-1:0];
	end

	// compare and fallback route
	always_comb begin
		hit         = (mem_rdata[ENTRY_W-1 -: KEY_W] == key_q);
		last        = (idx_inc == count_q);
		dflt_status = default_valid_q ? STATUS_DEFAULT : STATUS_MISS;
		dflt_ip     = default_valid_q ? default_ip_q : '0;
		dflt_port   = default_valid_q ? default_port_q : '0;
		out_free    = !out_valid_q || rsp.ready;
		if (count_q > CNT_W'(255)) begin
			count_sat = 8'hff;
		end else begin
			count_sat = COUNT_W'(count_q);
		end
	end

	assign req.ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q <= '0;
					case (op_q)
						OP_ADD: begin
							if (count_q < DEPTH_C) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= S_DONE;
						end
						OP_CLEAR: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= (count_q == '0) ? S_DONE : S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					if (hit || last) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction capture and result registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.operation;
			key_q  <= normalise(req.callsign);
			ip_q   <= req.ip_addr;
			port_q <= req.dst_port;
		end
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_ADD: begin
					res_status_q <= (count_q < DEPTH_C) ? STATUS_ADDED : STATUS_FULL;
					res_ip_q     <= '0;
					res_port_q   <= '0;
				end
				OP_CLEAR: begin
					res_status_q <= STATUS_CLEARED;
					res_ip_q     <= '0;
					res_port_q   <= '0;
				end
				default: begin
					res_status_q <= dflt_status;
					res_ip_q     <= dflt_ip;
					res_port_q   <= dflt_port;
				end
			endcase
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				res_status_q <= STATUS_FOUND;
				res_ip_q     <= mem_rdata[PORT_W +: IP_W];
				res_port_q   <= mem_rdata[PORT_W-1:0];
			end else begin
				res_status_q <= dflt_status;
				res_ip_q     <= dflt_ip;
				res_port_q   <= dflt_port;
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_ip_q     <= res_ip_q;
			out_port_q   <= res_port_q;
			out_count_q  <= count_sat;
		end
	end

	// output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.route_ip    = out_ip_q;
	assign rsp.route_port  = out_port_q;
	assign rsp.entry_count = out_count_q;

	// default route registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_valid_q <= 1'b0;
			default_ip_q    <= '0;
			default_port_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEFAULT_VALID: default_valid_q <= cfg_data[0];
				CFG_DEFAULT_IP:    default_ip_q    <= cfg_data;
				CFG_DEFAULT_PORT:  default_port_q  <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/callsign_route_table.sv @@
// ----------------------------------------------------------------------------
// callsign_route_table: maps ax.25 callsigns to an ip address and udp port
//
// req carries one operation per transaction: add a route, look up a
// callsign or clear the table. rsp returns exactly one result per request
// with a status, the route found and the number of routes held.
// Callsigns are normalised before they are stored or compared; a lookup
// returns the lowest matching entry, else the default route if enabled.
// The default route is set through the cfg_we/cfg_index/cfg_data port.
// An add or clear passes the EXEC and DONE states; a lookup passes EXEC,
// a scan through the entry memory at one entry per cycle up to the first
// match or the last entry held, and DONE. DONE loads the output register,
// and so raises rsp valid, once that register is free. One request is in
// flight at a time; req.ready is high while the block is idle and rises
// in the same cycle as the result is loaded into the output register.
// A finished result sits in an output register, so a stalled rsp
// does not block the next request from being taken and worked on.
// Reset empties the table (count to zero) and disables the default route;
// the entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
module callsign_route_table #(
	parameter int TABLE_DEPTH = crt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	crt_req_if.sink             req,
	crt_rsp_if.source           rsp,
	input  logic                cfg_we,
	input  crt_pkg::cfg_idx_t   cfg_index,
	input  crt_pkg::cfg_data_t  cfg_data
);
	import crt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;

	// sequencer and result registers
	crt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// route entry storage
	crt_mem #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the callsign route table
// Drives add, lookup and clear transactions with random gaps and response
// stalls, predicts every response from a shadow copy of the route table and
// the default route, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crt_pkg::*;

	// codes the package leaves unnamed
	localparam op_t      OP_SPARE   = 2'd3;
	localparam cfg_idx_t CFG_UNUSED = 2'd3;

	// bits that normalisation throws away: low bit of each character, ssid extras
	localparam key_t IGNORED_BITS = 56'h01_01_01_01_01_01_e1;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 240;

	typedef struct packed {
		status_t status;
		ip_t     ip;
		port_t   port;
		count_t  count;
	} route_result_t;

	// shadow route table and the queue of responses still owed
	class route_scoreboard;
		localparam int DEPTH = DEFAULT_TABLE_DEPTH;

		key_t          keys  [DEPTH];
		ip_t           ips   [DEPTH];
		port_t         ports [DEPTH];
		int            held;
		logic          dflt_on;
		ip_t           dflt_ip;
		port_t         dflt_port;
		route_result_t owed_replies[$];
		int            errors;

		function new();
			held      = 0;
			dflt_on   = 1'b0;
			dflt_ip   = '0;
			dflt_port = '0;
			errors    = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				CFG_DEFAULT_VALID: dflt_on   = data[0];
				CFG_DEFAULT_IP:    dflt_ip   = data[IP_W-1:0];
				CFG_DEFAULT_PORT:  dflt_port = data[PORT_W-1:0];
				default: ;
			endcase
		endfunction

		// canonical form used for storing and matching callsigns
		function key_t canon_callsign(key_t raw);
			return {raw[55:8] & CHAR_MASK, (raw[7:0] & SSID_KEEP) | SSID_SET};
		endfunction

		// apply one accepted request and queue the response it must produce
		function void take_request(op_t op, key_t raw, ip_t ip, port_t port);
			route_result_t r;
			key_t          k;
			logic          hit;
			k   = canon_callsign(raw);
			r   = '0;
			hit = 1'b0;
			case (op)
				OP_ADD: begin
					if (held < DEPTH) begin
						keys[held]  = k;
						ips[held]   = ip;
						ports[held] = port;
						held++;
						r.status = STATUS_ADDED;
					end else begin
						r.status = STATUS_FULL;
					end
				end
				OP_CLEAR: begin
					held     = 0;
					r.status = STATUS_CLEARED;
				end
				default: begin
					// lowest matching entry wins, then the default route
					for (int i = 0; i < held && !hit; i++) begin
						if (keys[i] == k) begin
							hit    = 1'b1;
							r.ip   = ips[i];
							r.port = ports[i];
						end
					end
					if (hit) begin
						r.status = STATUS_FOUND;
					end else if (dflt_on) begin
						r.status = STATUS_DEFAULT;
						r.ip     = dflt_ip;
						r.port   = dflt_port;
					end else begin
						r.status = STATUS_MISS;
					end
				end
			endcase
			r.count = (held > 255) ? 8'd255 : count_t'(held);
			owed_replies.push_back(r);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check(status_t st, ip_t ip, port_t port, count_t cnt);
			route_result_t want;
			if (owed_replies.size() == 0) begin
				report($sformatf("response with none outstanding (status %0d)", st));
				return;
			end
			want = owed_replies.pop_front();
			if (st != want.status)
				report($sformatf("status %0d, want %0d", st, want.status));
			if (ip != want.ip)
				report($sformatf("route_ip %h, want %h", ip, want.ip));
			if (port != want.port)
				report($sformatf("route_port %h, want %h", port, want.port));
			if (cnt != want.count)
				report($sformatf("entry_count %0d, want %0d", cnt, want.count));
		endtask

		function int pending();
			return owed_replies.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      gap_on;
	logic      stall_on;

	route_scoreboard sb = new();
	key_t            known_calls[$];

	crt_req_if req_ch ();
	crt_rsp_if rsp_ch ();

	callsign_route_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one request and hold it until the transaction completes
	task automatic send_request(op_t op, key_t cs, ip_t ip, port_t port);
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.callsign  <= cs;
		req_ch.ip_addr   <= ip;
		req_ch.dst_port  <= port;
		do @(posedge clk); while (!req_ch.ready);
		sb.take_request(op, cs, ip, port);
	endtask

	// random idle burst on the request side
	task automatic pause_sender();
		if (gap_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed response has arrived
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// program the default route, with random upper bits and a stray index
	task automatic set_defaults(logic enable, ip_t ip, port_t port);
		cfg_idx_t  order [4];
		cfg_data_t word  [4];
		order   = '{CFG_UNUSED, CFG_DEFAULT_VALID, CFG_DEFAULT_IP, CFG_DEFAULT_PORT};
		word[0] = $urandom;
		word[1] = $urandom;
		word[1][0] = enable;
		word[2] = ip;
		word[3] = $urandom;
		word[3][PORT_W-1:0] = port;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= word[i];
			sb.write_reg(order[i], word[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// same callsign after normalisation, different raw bits
	function automatic key_t respell(key_t cs);
		logic [63:0] w;
		w = {$urandom, $urandom};
		return cs ^ (w[55:0] & IGNORED_BITS);
	endfunction

	// one random request; lookups mostly aim at callsigns already added
	task automatic random_request(int add_pm, int clear_pm);
		int          roll;
		op_t         op;
		key_t        cs;
		logic [63:0] w;
		roll = $urandom_range(0, 999);
		w    = {$urandom, $urandom};
		if (roll < clear_pm)
			op = OP_CLEAR;
		else if (roll < clear_pm + add_pm)
			op = OP_ADD;
		else
			op = ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_LOOKUP;
		if (known_calls.size() != 0 &&
				$urandom_range(0, 99) < ((op == OP_ADD) ? 25 : 70)) begin
			cs = respell(known_calls[$urandom_range(0, known_calls.size() - 1)]);
		end else begin
			cs = w[55:0];
			if (op == OP_ADD) begin
				if (known_calls.size() >= 256)
					void'(known_calls.pop_front());
				known_calls.push_back(cs);
			end
		end
		send_request(op, cs, $urandom, port_t'($urandom));
	endtask

	// reset, directed checks, then random phases
	initial begin
		int    add_pm;
		int    clear_pm;
		ip_t   d_ip;
		port_t d_port;
		logic  d_on;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_DEFAULT_VALID;
		cfg_data         = '0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_ADD;
		req_ch.callsign  = '0;
		req_ch.ip_addr   = '0;
		req_ch.dst_port  = '0;
		gap_on           = 1'b1;
		stall_on         = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, aliases, duplicates, spare opcode, clear
		set_defaults(1'b0, '0, '0);
		send_request(OP_LOOKUP, '0, '0, '0);
		send_request(OP_ADD, '0, '0, '0);
		send_request(OP_ADD, '1, '1, '1);
		send_request(OP_LOOKUP, '1, '0, '0);
		send_request(OP_LOOKUP, IGNORED_BITS, '1, '1);
		send_request(OP_LOOKUP, 56'hfe_fe_fe_fe_fe_fe_1e, '0, '0);
		send_request(OP_ADD, '1, 32'h0a00_0001, 16'd1);
		send_request(OP_LOOKUP, 56'hff_fe_ff_fe_ff_fe_7f, '0, '0);
		send_request(OP_LOOKUP, 56'ha0_82_86_a4_40_40_60, '0, '0);
		send_request(OP_SPARE, '1, '0, '0);
		send_request(OP_SPARE, 56'ha0_82_86_a4_40_40_60, '1, '1);
		send_request(OP_CLEAR, '1, '1, '1);
		send_request(OP_LOOKUP, '1, '0, '0);
		settle();

		// default route with a raw ip target
		set_defaults(1'b1, '1, '0);
		send_request(OP_LOOKUP, '0, '0, '0);
		send_request(OP_ADD, 56'h9c_6e_8a_98_ac_a4_e0, 32'hc0a8_0001, 16'd4000);
		send_request(OP_LOOKUP, 56'h9d_6f_8b_99_ad_a5_61, '0, '0);
		send_request(OP_LOOKUP, '1, '0, '0);
		send_request(OP_CLEAR, '0, '0, '0);
		send_request(OP_CLEAR, '0, '0, '0);
		settle();

		// random phases, each under its own default route and idling pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin d_on = 1'b0; d_ip = '0; d_port = '0; end
				1: begin d_on = 1'b1; d_ip = '1; d_port = '1; end
				2: begin d_on = 1'b1; d_ip = '0; d_port = '0; end
				default: begin
					d_on   = ($urandom_range(0, 1) != 0);
					d_ip   = $urandom;
					d_port = port_t'($urandom);
				end
			endcase
			set_defaults(d_on, d_ip, d_port);
			case (ph)
				0:       begin add_pm = 550; clear_pm = 10; end
				1:       begin add_pm = 850; clear_pm = 0;  end
				2:       begin add_pm = 250; clear_pm = 10; end
				3:       begin add_pm = 450; clear_pm = 30; end
				4:       begin add_pm = 700; clear_pm = 4;  end
				5:       begin add_pm = 350; clear_pm = 15; end
				6:       begin add_pm = 900; clear_pm = 2;  end
				default: begin add_pm = 500; clear_pm = 10; end
			endcase
			gap_on   = (ph < PHASES - 1) && ph != 2 && ph != 5;
			stall_on = (ph < PHASES - 1) && ph != 2 && ph != 4;
			repeat (ITEMS_PER_PHASE) begin
				pause_sender();
				random_request(add_pm, clear_pm);
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// response side: random stall bursts
	initial begin
		rsp_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// check every completed response transaction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check(rsp_ch.status, rsp_ch.route_ip, rsp_ch.route_port, rsp_ch.entry_count);
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
